// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk with active-low rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define APC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define APC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define APC_ASSERT_IMP(lbl, ante, cons)
`define APC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/apc_pkg.sv =====
// ----------------------------------------------------------------------------
// apc_pkg
// shared types, constants and elaboration-time tables of the phaser
// ----------------------------------------------------------------------------
package apc_pkg;

    localparam int DIV_DW = 48;
    localparam int DIV_VW = 32;
    localparam int DIV_CW = 6;

    localparam logic [1:0] REG_RATE  = 2'd0;
    localparam logic [1:0] REG_SWEEP = 2'd1;
    localparam logic [1:0] REG_REGEN = 2'd2;

    localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

    // taylor divisors (2k)(2k+1), entry 0 unused
    typedef logic [7:0] sdiv_tab_t [0:7];
    localparam sdiv_tab_t SINE_DIV = '{8'd1, 8'd6, 8'd20, 8'd42, 8'd72, 8'd110,
                                        8'd156, 8'd210};

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } apc_div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_DW-1:0] quotient;
    } apc_div_stat_t;

    typedef logic [17:0] span_tab_t [0:100];
    typedef logic [15:0] gain_tab_t [0:100];
    typedef logic [30:0] root_tab_t [0:16];

    function automatic logic [6:0] knob(input logic [6:0] v);
        return (v > 7'd100) ? 7'd100 : v;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [51:0] v);
        if (v > 52'sd8388607)
            return 24'sh7FFFFF;
        else if (v < -52'sd8388608)
            return 24'sh800000;
        else
            return v[23:0];
    endfunction

    // floor of p / 2^16 + 1/2
    function automatic logic signed [51:0] rnd16(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = (p + 66'sd32768) >>> 16;
        return t[51:0];
    endfunction

    // elaboration-only sine of a turn fraction, q30
    function automatic longint sin_q30_f(input logic [31:0] ph);
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned m;
        longint sum;
        r = longint'(ph[29:0]);
        if (ph[30])
            r = (64'd1 << 30) - r;
        x = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        m = x;
        sum = longint'(x);
        // taylor terms up to x^15, signs alternate
        m = ((m * x2) >> 30) / 64'd6;
        sum = sum - longint'(m);
        m = ((m * x2) >> 30) / 64'd20;
        sum = sum + longint'(m);
        m = ((m * x2) >> 30) / 64'd42;
        sum = sum - longint'(m);
        m = ((m * x2) >> 30) / 64'd72;
        sum = sum + longint'(m);
        m = ((m * x2) >> 30) / 64'd110;
        sum = sum - longint'(m);
        m = ((m * x2) >> 30) / 64'd156;
        sum = sum + longint'(m);
        m = ((m * x2) >> 30) / 64'd210;
        sum = sum - longint'(m);
        if (sum < 0)
            sum = 0;
        if (sum > (64'sd1 <<< 30))
            sum = 64'sd1 <<< 30;
        return ph[31] ? -sum : sum;
    endfunction

    function automatic span_tab_t build_span();
        span_tab_t t;
        longint unsigned x;
        int unsigned ip;
        int unsigned fr;
        for (int i = 0; i <= 100; i++)
        begin
            x = (longint'(100 + 9 * i) << 30) / 100;
            ip = 0;
            fr = 0;
            for (int j = 0; j < 4; j++)
                if (x >= (64'd1 << 31))
                begin
                    x = x >> 1;
                    ip++;
                end
            for (int b = 15; b >= 0; b--)
            begin
                x = (x * x) >> 30;
                if (x >= (64'd1 << 31))
                begin
                    x = x >> 1;
                    fr = fr | (1 << b);
                end
            end
            t[i] = 18'((ip << 16) | fr);
        end
        return t;
    endfunction

    function automatic gain_tab_t build_gain();
        gain_tab_t t;
        for (int i = 0; i <= 100; i++)
            t[i] = 16'((i * 458752 + 500) / 1000);
        return t;
    endfunction

    function automatic root_tab_t build_root();
        root_tab_t t;
        longint unsigned prev;
        longint unsigned v;
        longint unsigned res;
        longint unsigned bitv;
        prev = 64'd1 << 31;
        t[0] = 31'h7FFF_FFFF;
        for (int k = 1; k <= 16; k++)
        begin
            v = prev << 30;
            res = 0;
            bitv = 64'd1 << 62;
            for (int j = 0; j < 32; j++)
            begin
                if (bitv > v)
                    bitv = bitv >> 2;
            end
            for (int j = 0; j < 32; j++)
            begin
                if (bitv != 0)
                begin
                    if (v >= res + bitv)
                    begin
                        v = v - (res + bitv);
                        res = (res >> 1) + bitv;
                    end
                    else
                        res = res >> 1;
                    bitv = bitv >> 2;
                end
            end
            t[k] = 31'(res);
            prev = res;
        end
        return t;
    endfunction

    localparam span_tab_t SPAN_TAB = build_span();
    localparam gain_tab_t GAIN_TAB = build_gain();
    localparam root_tab_t ROOT_TAB = build_root();

endpackage

// ===== rtl/allpass_cascade_phaser.sv =====
// one item at a time: s_tready is high only in the idle state
// the bit-serial divider takes most of the time spent on each item
// (up to sixteen divisions: theta, fourteen taylor terms, coefficient)
// a finished result waits in the output register while the next item is taken
// reset: async active low; knobs to 50/50/0, lfo phase, stage history and
// feedback sample to zero
// ----------------------------------------------------------------------------
// allpass_cascade_phaser
// lfo-swept cascade of first-order allpass stages with feedback and dry mix
// ----------------------------------------------------------------------------
module allpass_cascade_phaser
#(
    parameter int STAGE_COUNT     = 4,
    parameter int SAMPLE_RATE     = 48000,
    parameter int SINE_TABLE_BITS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [6:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] sample_in
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [23:0] sample_out
);
    import apc_pkg::*;

`include "assert_macros.svh"

    localparam int LFO_SIZE = 1 << SINE_TABLE_BITS;
    localparam int CNT_W    = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
    // phase step denominator, 10000 * fs
    localparam longint INC_DEN = 10000 * longint'(SAMPLE_RATE);

    // phase step per knob position, 2^32 = one turn
    typedef logic [31:0] inc_tab_t [0:100];
    // lfo in q16, 0..65536
    typedef logic [16:0] lfo_tab_t [0:LFO_SIZE-1];

    function automatic inc_tab_t build_inc();
        inc_tab_t t;
        for (int i = 0; i <= 100; i++)
            t[i] = 32'((longint'(500 + 195 * i) << 32) / INC_DEN);
        return t;
    endfunction

    function automatic lfo_tab_t build_lfo();
        lfo_tab_t t;
        longint s;
        for (int i = 0; i < LFO_SIZE; i++)
        begin
            s = sin_q30_f(32'(longint'(i) << (32 - SINE_TABLE_BITS)));
            t[i] = 17'((s + (64'sd1 <<< 30) + 64'sd16384) >>> 15);
        end
        return t;
    endfunction

    localparam inc_tab_t INC_TAB = build_inc();
    localparam lfo_tab_t LFO_TAB = build_lfo();

    typedef enum logic [23:0] {
        ST_IDLE  = 24'h000001,
        ST_LFO   = 24'h000002,
        ST_EMUL  = 24'h000004,
        ST_EXP   = 24'h000008,
        ST_RMUL  = 24'h000010,
        ST_RACC  = 24'h000020,
        ST_FCMUL = 24'h000040,
        ST_FC    = 24'h000080,
        ST_THDIV = 24'h000100,
        ST_SIN0  = 24'h000200,
        ST_SIN1  = 24'h000400,
        ST_SIN2  = 24'h000800,
        ST_SIN3  = 24'h001000,
        ST_SIN4  = 24'h002000,
        ST_SIN5  = 24'h004000,
        ST_SIN6  = 24'h008000,
        ST_SIN7  = 24'h010000,
        ST_ADIV  = 24'h020000,
        ST_AWAIT = 24'h040000,
        ST_FBMUL = 24'h080000,
        ST_FB    = 24'h100000,
        ST_STMUL = 24'h200000,
        ST_ST    = 24'h400000,
        ST_MIX   = 24'h800000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // knobs
    logic [6:0] rate_reg;
    logic [6:0] sweep_reg;
    logic [6:0] regen_reg;

    // persistent filter state
    logic [31:0]        phase_reg;
    logic signed [23:0] last_wet_reg;
    logic signed [23:0] pin_reg  [STAGE_COUNT];
    logic signed [23:0] pout_reg [STAGE_COUNT];

    // per-item working registers
    logic signed [23:0] sample_reg;
    logic [16:0]        lfo_reg;
    logic [2:0]         ip_reg;
    logic [15:0]        frac_reg;
    logic [30:0]        m_reg;
    logic [4:0]         k_reg;
    logic [31:0]        ph_reg;
    logic               sel_reg;
    logic [1:0]         quad_reg;
    logic [30:0]        xs_reg;
    logic [31:0]        x2_reg;
    logic [31:0]        tm_reg;
    logic [2:0]         sk_reg;
    logic signed [34:0] sum_reg;
    logic signed [31:0] s_reg;
    logic signed [31:0] c_reg;
    logic signed [17:0] a_reg;
    logic               neg_reg;
    logic signed [23:0] x_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               out_valid_reg;
    logic [23:0]        out_data_reg;

    // shared multiplier, product registered
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod_reg;

    apc_div_req_t  div_req;
    apc_div_stat_t div_stat;

    apc_sdiv u_sdiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // derived values
    logic [30:0]        sin_r;
    logic [46:0]        fc_shift;
    logic signed [32:0] den;
    logic signed [32:0] num;
    logic [31:0]        num_abs;
    logic signed [24:0] diff;
    logic signed [34:0] qv;
    logic signed [31:0] sin_res;
    logic [30:0]        sin_clamp;
    logic signed [24:0] mix_sum;
    logic               in_fire;
    logic               out_free;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // reflect the quarter wave on odd quadrants
    assign sin_r    = ph_reg[30] ? (Q30_ONE - {1'b0, ph_reg[29:0]}) : {1'b0, ph_reg[29:0]};
    assign fc_shift = {7'd0, prod_reg[39:0]} << ip_reg;
    assign den      = {s_reg[31], s_reg} + {c_reg[31], c_reg};
    assign num      = {s_reg[31], s_reg} - {c_reg[31], c_reg};
    assign num_abs  = num[32] ? 32'(-num) : num[31:0];
    assign diff     = {x_reg[23], x_reg} - {pout_reg[0][23], pout_reg[0]};
    assign qv       = {3'b000, div_stat.quotient[31:0]};
    assign mix_sum  = {sample_reg[23], sample_reg} + {x_reg[23], x_reg};

    always_comb
    begin
        if (sum_reg < 35'sd0)
            sin_clamp = '0;
        else if (sum_reg > $signed({4'b0000, Q30_ONE}))
            sin_clamp = Q30_ONE;
        else
            sin_clamp = sum_reg[30:0];
        sin_res = quad_reg[1] ? -$signed({1'b0, sin_clamp}) : $signed({1'b0, sin_clamp});
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_EMUL:
            begin
                mul_a = {16'd0, lfo_reg};
                mul_b = {15'd0, SPAN_TAB[knob(sweep_reg)]};
            end
            ST_RMUL:
            begin
                mul_a = {2'b00, m_reg};
                mul_b = {2'b00, ROOT_TAB[k_reg]};
            end
            ST_FCMUL:
            begin
                mul_a = {2'b00, m_reg};
                mul_b = 33'sd200;
            end
            ST_SIN0:
            begin
                mul_a = {2'b00, sin_r};
                mul_b = HALF_PI_Q30;
            end
            ST_SIN2:
            begin
                mul_a = {2'b00, xs_reg};
                mul_b = {2'b00, xs_reg};
            end
            ST_SIN4:
            begin
                mul_a = {1'b0, tm_reg};
                mul_b = {1'b0, x2_reg};
            end
            ST_FBMUL:
            begin
                mul_a = {{9{last_wet_reg[23]}}, last_wet_reg};
                mul_b = {17'd0, GAIN_TAB[knob(regen_reg)]};
            end
            ST_STMUL:
            begin
                mul_a = {{15{a_reg[17]}}, a_reg};
                mul_b = {{8{diff[24]}}, diff};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // divider launch
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            ST_FC:
            begin
                // theta = fc_q8 * 2^23 / fs
                div_req.start    = 1'b1;
                div_req.dividend = {fc_shift[46:22], 23'd0};
                div_req.divisor  = 32'(SAMPLE_RATE);
            end
            ST_SIN5:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {15'd0, prod_reg[62:30]};
                div_req.divisor  = {24'd0, SINE_DIV[sk_reg]};
            end
            ST_ADIV:
            begin
                div_req.start    = (den > 33'sd0);
                div_req.dividend = {num_abs, 16'd0};
                div_req.divisor  = den[31:0];
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_LFO;
            ST_LFO:   state_next = ST_EMUL;
            ST_EMUL:  state_next = ST_EXP;
            ST_EXP:   state_next = ST_RMUL;
            ST_RMUL:  state_next = ST_RACC;
            ST_RACC:  state_next = (k_reg == 5'd16) ? ST_FCMUL : ST_RMUL;
            ST_FCMUL: state_next = ST_FC;
            ST_FC:    state_next = ST_THDIV;
            ST_THDIV: if (div_stat.done) state_next = ST_SIN0;
            ST_SIN0:  state_next = ST_SIN1;
            ST_SIN1:  state_next = ST_SIN2;
            ST_SIN2:  state_next = ST_SIN3;
            ST_SIN3:  state_next = ST_SIN4;
            ST_SIN4:  state_next = ST_SIN5;
            ST_SIN5:  state_next = ST_SIN6;
            ST_SIN6:  if (div_stat.done) state_next = (sk_reg == 3'd7) ? ST_SIN7 : ST_SIN4;
            ST_SIN7:  state_next = sel_reg ? ST_ADIV : ST_SIN0;
            ST_ADIV:  state_next = (den > 33'sd0) ? ST_AWAIT : ST_FBMUL;
            ST_AWAIT: if (div_stat.done) state_next = ST_FBMUL;
            ST_FBMUL: state_next = ST_FB;
            ST_FB:    state_next = ST_STMUL;
            ST_STMUL: state_next = ST_ST;
            ST_ST:    state_next = (cnt_reg == CNT_W'(STAGE_COUNT - 1)) ? ST_MIX : ST_STMUL;
            ST_MIX:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rate_reg      <= 7'd50;
            sweep_reg     <= 7'd50;
            regen_reg     <= 7'd0;
            phase_reg     <= '0;
            last_wet_reg  <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            for (int i = 0; i < STAGE_COUNT; i++)
            begin
                pin_reg[i]  <= '0;
                pout_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_RATE:  rate_reg  <= cfg_data;
                    REG_SWEEP: sweep_reg <= cfg_data;
                    REG_REGEN: regen_reg <= cfg_data;
                    default:   ;
                endcase
            end

            // lfo advances once per accepted item
            if (in_fire)
                phase_reg <= phase_reg + INC_TAB[knob(rate_reg)];

            if (state_reg == ST_FB)
                cnt_reg <= '0;
            else if (state_reg == ST_ST)
                cnt_reg <= cnt_reg + 1'b1;

            // stage history rotates: head is the stage in work, tail gets its update
            if (state_reg == ST_ST)
            begin
                for (int i = 0; i < STAGE_COUNT - 1; i++)
                begin
                    pin_reg[i]  <= pin_reg[i + 1];
                    pout_reg[i] <= pout_reg[i + 1];
                end
                pin_reg[STAGE_COUNT - 1]  <= x_reg;
                pout_reg[STAGE_COUNT - 1] <= sat24(rnd16(prod_reg) +
                                                   {{28{pin_reg[0][23]}}, pin_reg[0]});
            end

            if (state_reg == ST_MIX && out_free)
            begin
                out_valid_reg <= 1'b1;
                last_wet_reg  <= x_reg;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_reg <= $signed(s_tdata);
            end
            ST_LFO:
            begin
                lfo_reg <= LFO_TAB[phase_reg[31 -: SINE_TABLE_BITS]];
            end
            ST_EXP:
            begin
                ip_reg   <= prod_reg[34:32];
                frac_reg <= prod_reg[31:16];
                m_reg    <= Q30_ONE;
                k_reg    <= 5'd1;
            end
            ST_RACC:
            begin
                // 2^frac as a product of 2^(2^-k) terms
                if (frac_reg[4'(5'd16 - k_reg)])
                    m_reg <= prod_reg[60:30];
                k_reg <= k_reg + 1'b1;
            end
            ST_THDIV:
            begin
                ph_reg  <= div_stat.quotient[31:0];
                sel_reg <= 1'b0;
            end
            ST_SIN0:
            begin
                quad_reg <= ph_reg[31:30];
            end
            ST_SIN1:
            begin
                xs_reg <= prod_reg[60:30];
            end
            ST_SIN3:
            begin
                x2_reg  <= prod_reg[61:30];
                tm_reg  <= {1'b0, xs_reg};
                sum_reg <= {4'b0000, xs_reg};
                sk_reg  <= 3'd1;
            end
            ST_SIN6:
            begin
                if (div_stat.done)
                begin
                    tm_reg  <= div_stat.quotient[31:0];
                    sum_reg <= sk_reg[0] ? (sum_reg - qv) : (sum_reg + qv);
                    sk_reg  <= sk_reg + 1'b1;
                end
            end
            ST_SIN7:
            begin
                // first pass gives sine, second the cosine
                if (sel_reg)
                    c_reg <= sin_res;
                else
                begin
                    s_reg   <= sin_res;
                    ph_reg  <= ph_reg + 32'h4000_0000;
                    sel_reg <= 1'b1;
                end
            end
            ST_ADIV:
            begin
                neg_reg <= num[32];
                a_reg   <= '0;
            end
            ST_AWAIT:
            begin
                if (div_stat.done)
                    a_reg <= neg_reg ? -$signed(div_stat.quotient[17:0])
                                     : $signed(div_stat.quotient[17:0]);
            end
            ST_FB:
            begin
                x_reg <= sat24({{28{sample_reg[23]}}, sample_reg} + rnd16(prod_reg));
            end
            ST_ST:
            begin
                x_reg <= sat24(rnd16(prod_reg) + {{28{pin_reg[0][23]}}, pin_reg[0]});
            end
            ST_MIX:
            begin
                if (out_free)
                    out_data_reg <= mix_sum[24:1];
            end
            default:
            begin
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks
    `APC_ASSERT_IMP(a_idle_div_quiet, s_tready, !div_stat.busy)
    `APC_ASSERT_NXT(a_accept_closes, in_fire, !s_tready)
    `APC_ASSERT_IMP(a_result_from_mix, $rose(m_tvalid), $past(state_reg == ST_MIX))

endmodule

// ===== rtl/apc_sdiv.sv =====
// ----------------------------------------------------------------------------
// apc_sdiv
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module apc_sdiv
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  apc_pkg::apc_div_req_t  req,
    output apc_pkg::apc_div_stat_t stat
);
    import apc_pkg::*;

    logic [DIV_DW-1:0] quo_reg;
    logic [DIV_VW-1:0] rem_reg;
    logic [DIV_VW-1:0] dvs_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_VW:0]   trial;
    logic [DIV_VW:0]   diff;
    logic              ge;

    assign trial = {rem_reg, quo_reg[DIV_DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_DW-2:0], ge};
            rem_reg <= ge ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule
